[rtl/nicdq_pkg.sv]
// ----------------------------------------------------------------------------
// nicdq_pkg
// Shared types and codes for the NIC descriptor queue register block.
// ----------------------------------------------------------------------------
package nicdq_pkg;

    localparam int CNT_W    = 4;   // descriptor and completion counters
    localparam int ADDR_W   = 48;  // transmit address and MAC width
    localparam int LEN_W    = 16;  // frame length width
    localparam int WORD_W   = 64;  // bus word width
    localparam int OFS_W    = 5;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;
    localparam int RES_W    = 216; // result tdata, padded to whole bytes

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FRAME = 2'd2;

    localparam logic [OFS_W-1:0] OFS_SEND_REQ  = 5'd0;
    localparam logic [OFS_W-1:0] OFS_RECV_REQ  = 5'd8;
    localparam logic [OFS_W-1:0] OFS_SEND_COMP = 5'd16;
    localparam logic [OFS_W-1:0] OFS_RECV_COMP = 5'd18;
    localparam logic [OFS_W-1:0] OFS_COUNTS    = 5'd20;
    localparam logic [OFS_W-1:0] OFS_MAC       = 5'd24;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADOFS = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_DROP   = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture input word, read buffer memories
        logic exec;   // update queue state, load result register
    } dp_cmd_t;

endpackage

[rtl/nicdq_ctrl.sv]
// ----------------------------------------------------------------------------
// nicdq_ctrl
// Two-state sequencer: capture a word, then execute it into the output register.
// ----------------------------------------------------------------------------
module nicdq_ctrl
    import nicdq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_EXEC: begin
                cmd.exec = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)     out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[rtl/nicdq_dpath.sv]
// ----------------------------------------------------------------------------
// nicdq_dpath
// Queue counters, receive buffer memories, MAC register and result register.
// ----------------------------------------------------------------------------
module nicdq_dpath
    import nicdq_pkg::*;
#(
    parameter int RX_SLOTS = 8,
    parameter int TX_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    input  logic [ACT_W-1:0]  in_action,
    input  logic [OFS_W-1:0]  in_offset,
    input  logic [WORD_W-1:0] in_wdata,
    input  logic [LEN_W-1:0]  in_flen,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    output logic [RES_W-1:0]  res_data,
    output logic [STAT_W-1:0] res_status
);

    localparam int IDX_W = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
    localparam logic [CNT_W-1:0] RX_SLOTS_C = CNT_W'(RX_SLOTS);
    localparam logic [CNT_W-1:0] TX_SLOTS_C = CNT_W'(TX_SLOTS);

    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] head,
                                                    input logic [CNT_W-1:0] n);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(n);
        if (sum >= (CNT_W+1)'(RX_SLOTS)) sum = sum - (CNT_W+1)'(RX_SLOTS);
        return IDX_W'(sum);
    endfunction

    // captured word
    logic [ACT_W-1:0]  act_reg;
    logic [OFS_W-1:0]  ofs_reg;
    logic [WORD_W-1:0] wdata_reg;
    logic [LEN_W-1:0]  flen_reg;

    // queue state
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  posted_reg, posted_next;
    logic [CNT_W-1:0]  rx_done_reg, rx_done_next;
    logic [CNT_W-1:0]  tx_done_reg, tx_done_next;
    logic [ADDR_W-1:0] mac_reg;

    // receive buffer memories
    logic [WORD_W-1:0] addr_mem [RX_SLOTS];
    logic [LEN_W-1:0]  len_mem  [RX_SLOTS];
    logic [WORD_W-1:0] addr_rd_reg;
    logic [LEN_W-1:0]  len_rd_reg;
    logic              addr_we, len_we;
    logic [IDX_W-1:0]  slot_posted, slot_done;

    // result fields
    logic [WORD_W-1:0] rdata_next, rdata_reg;
    logic [STAT_W-1:0] status_next, status_reg;
    logic              txv_next, txv_reg;
    logic [ADDR_W-1:0] txa_next, txa_reg;
    logic [LEN_W-1:0]  txl_next, txl_reg;
    logic              rxv_next, rxv_reg;
    logic [WORD_W-1:0] rxa_next, rxa_reg;
    logic [LEN_W-1:0]  rxl_next, rxl_reg;

    assign slot_posted = slot_after(head_reg, posted_reg);
    assign slot_done   = slot_after(head_reg, rx_done_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= in_action;
            ofs_reg   <= in_offset;
            wdata_reg <= in_wdata;
            flen_reg  <= in_flen;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && addr_we) addr_mem[slot_posted] <= wdata_reg;
        if (cmd.load)            addr_rd_reg <= addr_mem[slot_done];
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && len_we) len_mem[slot_done] <= flen_reg;
        if (cmd.load)           len_rd_reg <= len_mem[head_reg];
    end

    always_comb begin
        rdata_next   = '0;
        status_next  = ST_OK;
        txv_next     = 1'b0;
        txa_next     = '0;
        txl_next     = '0;
        rxv_next     = 1'b0;
        rxa_next     = '0;
        rxl_next     = '0;
        head_next    = head_reg;
        posted_next  = posted_reg;
        rx_done_next = rx_done_reg;
        tx_done_next = tx_done_reg;
        addr_we      = 1'b0;
        len_we       = 1'b0;
        case (act_reg)
            ACT_READ: begin
                case (ofs_reg)
                    OFS_SEND_COMP: begin
                        if (tx_done_reg == '0) status_next = ST_EMPTY;
                        else tx_done_next = tx_done_reg - 1'b1;
                    end
                    OFS_RECV_COMP: begin
                        if (rx_done_reg == '0 || posted_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            rdata_next   = WORD_W'(len_rd_reg);
                            head_next    = slot_after(head_reg, CNT_W'(1));
                            rx_done_next = rx_done_reg - 1'b1;
                            posted_next  = posted_reg - 1'b1;
                        end
                    end
                    OFS_COUNTS: begin
                        rdata_next = WORD_W'({rx_done_reg, tx_done_reg,
                                              RX_SLOTS_C - posted_reg, TX_SLOTS_C});
                    end
                    OFS_MAC: rdata_next = WORD_W'(mac_reg);
                    default: status_next = ST_BADOFS;
                endcase
            end
            ACT_WRITE: begin
                case (ofs_reg)
                    OFS_SEND_REQ: begin
                        if (tx_done_reg == CNT_MAX) begin
                            status_next = ST_FULL;
                        end else begin
                            txv_next     = 1'b1;
                            txa_next     = wdata_reg[ADDR_W-1:0];
                            txl_next     = wdata_reg[WORD_W-1:ADDR_W];
                            tx_done_next = tx_done_reg + 1'b1;
                        end
                    end
                    OFS_RECV_REQ: begin
                        if (posted_reg >= RX_SLOTS_C) begin
                            status_next = ST_FULL;
                        end else begin
                            addr_we     = 1'b1;
                            posted_next = posted_reg + 1'b1;
                        end
                    end
                    default: status_next = ST_BADOFS;
                endcase
            end
            ACT_FRAME: begin
                if (rx_done_reg < posted_reg) begin
                    len_we       = 1'b1;
                    rxv_next     = 1'b1;
                    rxa_next     = addr_rd_reg;
                    rxl_next     = flen_reg;
                    rx_done_next = rx_done_reg + 1'b1;
                end else begin
                    status_next = ST_DROP;
                end
            end
            default: ;  // undefined action: zero result, no change
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            posted_reg  <= '0;
            rx_done_reg <= '0;
            tx_done_reg <= '0;
            mac_reg     <= '0;
        end else begin
            if (cmd.exec) begin
                head_reg    <= head_next;
                posted_reg  <= posted_next;
                rx_done_reg <= rx_done_next;
                tx_done_reg <= tx_done_next;
            end
            if (cfg_wr_en) mac_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rdata_reg  <= rdata_next;
            status_reg <= status_next;
            txv_reg    <= txv_next;
            txa_reg    <= txa_next;
            txl_reg    <= txl_next;
            rxv_reg    <= rxv_next;
            rxa_reg    <= rxa_next;
            rxl_reg    <= rxl_next;
        end
    end

    assign res_data   = RES_W'({rxl_reg, rxa_reg, rxv_reg, txl_reg, txa_reg, txv_reg,
                                rdata_reg});
    assign res_status = status_reg;

endmodule

[rtl/nic_descriptor_queue_registers.sv]
// ----------------------------------------------------------------------------
// nic_descriptor_queue_registers
// Register front end of a simple NIC: send/receive descriptor queue registers.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one word per bus read, bus write or frame arrival.
//    tuser holds the action; tdata holds offset, write word, frame length.
//  - m_axis returns exactly one result word per input word, in order:
//    read data, transmit command and receive buffer write, with the
//    status code in tuser.
//  - cfg_wr_en / cfg_wr_data load the 48-bit station MAC address; write it
//    only while no word is in flight.
//  - Each accepted word is first captured, which issues the registered read
//    of the receive buffer memories, then executed, which updates the queue
//    counters and loads the output register that drives m_axis_tvalid.
//    Execute waits while a held result fills the output register; a new
//    word is accepted only once the previous one has executed.
//  - Receiver stall: a held result does not block capture of the next word;
//    that word waits in its execute cycle until the output register frees.
//  - Reset (aresetn low, synchronous) empties both queues and clears the MAC.
//    Buffer memories are not cleared; entries are written before being read.
// ----------------------------------------------------------------------------
module nic_descriptor_queue_registers
    import nicdq_pkg::*;
#(
    parameter int RX_SLOTS = 8,   // receive ring depth, 1..15
    parameter int TX_SLOTS = 8    // reported free send slots, 1..15
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input words
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [4:0] offset, [68:5] wdata, [84:69] frame_length, [87:85] zero
    input  logic [87:0]       s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]  s_axis_tuser,
    // result words
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [63:0] rdata, [64] tx_valid, [112:65] tx_addr, [128:113] tx_len,
    // [129] rx_write_valid, [193:130] rx_write_addr, [209:194] rx_write_len,
    // [215:210] zero
    output logic [RES_W-1:0]  m_axis_tdata,
    // [2:0] status
    output logic [STAT_W-1:0] m_axis_tuser,
    // MAC address register
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data
);

    dp_cmd_t cmd;

    nicdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    nicdq_dpath #(
        .RX_SLOTS (RX_SLOTS),
        .TX_SLOTS (TX_SLOTS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_action   (s_axis_tuser),
        .in_offset   (s_axis_tdata[4:0]),
        .in_wdata    (s_axis_tdata[68:5]),
        .in_flen     (s_axis_tdata[84:69]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_data    (m_axis_tdata),
        .res_status  (m_axis_tuser)
    );

    // capture and execute never overlap
    a_no_load_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.exec))
        else $error("capture and execute in the same cycle");

    // an accepted word is always followed by its execute phase
    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // execute always presents a result next cycle
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_axis_tvalid)
        else $error("result missing after execute");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_axis_tvalid && !m_axis_tready && cmd.exec))
        else $error("held result overwritten");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NIC descriptor queue register block. Bus reads,
// bus writes and frame arrivals go in on s_axis. Every accepted word is run
// through a local model of the send counter, the receive ring and the MAC
// register. Each reply on m_axis is compared field by field with the oldest
// prediction. A short directed table comes first, then random descriptor
// traffic under four idling mixes, with a long receiver hold-off on the way.
// ----------------------------------------------------------------------------
module testbench;
    import nicdq_pkg::*;

    localparam int RING_SLOTS      = 8;
    localparam int SEND_SLOTS      = 8;
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int WORDS_PER_PHASE = 400;
    localparam int HOLD_CYCLES     = 400;
    localparam int SND_IDLE [4]    = '{0, 51, 0, 25};
    localparam int RCV_STALL [4]   = '{0, 0, 51, 25};

    // action code the block ignores, and two offsets that map nothing
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam logic [OFS_W-1:0] OFS_HOLE = 5'd4;
    localparam logic [OFS_W-1:0] OFS_TOP  = 5'd31;

    typedef struct packed {
        logic [WORD_W-1:0] rdata;
        logic [STAT_W-1:0] status;
        logic              tx_valid;
        logic [ADDR_W-1:0] tx_addr;
        logic [LEN_W-1:0]  tx_len;
        logic              rx_valid;
        logic [WORD_W-1:0] rx_addr;
        logic [LEN_W-1:0]  rx_len;
    } reply_t;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [OFS_W-1:0]  ofs;
        logic [WORD_W-1:0] wdata;
        logic [LEN_W-1:0]  flen;
        logic              fixed_exp;   // use the reply typed in below
        reply_t            want;
    } dir_row_t;

    localparam reply_t QUIET = '0;

    function automatic reply_t only_status(input logic [STAT_W-1:0] st);
        reply_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    // directed words: extremes, every register, empty, drop and bad-offset refusals
    dir_row_t dir_rows [25] = '{
        '{ACT_READ,  OFS_COUNTS,    64'd0, 16'd0, 1'b1,
          '{64'h88, ST_OK, 1'b0, 48'd0, 16'd0, 1'b0, 64'd0, 16'd0}},
        '{ACT_READ,  OFS_MAC,       64'd0, 16'd0, 1'b1, QUIET},
        '{ACT_READ,  OFS_SEND_COMP, 64'd0, 16'd0, 1'b1, only_status(ST_EMPTY)},
        '{ACT_READ,  OFS_RECV_COMP, 64'd0, 16'd0, 1'b1, only_status(ST_EMPTY)},
        '{ACT_FRAME, OFS_SEND_REQ,  64'd0, 16'hffff, 1'b1, only_status(ST_DROP)},
        '{ACT_READ,  OFS_TOP,       64'd0, 16'd0, 1'b1, only_status(ST_BADOFS)},
        '{ACT_READ,  OFS_HOLE,      64'd0, 16'd0, 1'b1, only_status(ST_BADOFS)},
        '{ACT_WRITE, OFS_SEND_COMP, 64'hffff_ffff_ffff_ffff, 16'd0, 1'b1,
          only_status(ST_BADOFS)},
        '{ACT_READ,  OFS_SEND_REQ,  64'd0, 16'd0, 1'b1, only_status(ST_BADOFS)},
        '{ACT_NONE,  OFS_TOP,       64'hffff_ffff_ffff_ffff, 16'hffff, 1'b1, QUIET},
        '{ACT_WRITE, OFS_SEND_REQ,  64'hffff_ffff_ffff_ffff, 16'd0, 1'b1,
          '{64'd0, ST_OK, 1'b1, 48'hffff_ffff_ffff, 16'hffff, 1'b0, 64'd0, 16'd0}},
        '{ACT_WRITE, OFS_SEND_REQ,  64'd0, 16'd0, 1'b1,
          '{64'd0, ST_OK, 1'b1, 48'd0, 16'd0, 1'b0, 64'd0, 16'd0}},
        '{ACT_WRITE, OFS_RECV_REQ,  64'hffff_ffff_ffff_ffff, 16'd0, 1'b1, QUIET},
        '{ACT_WRITE, OFS_RECV_REQ,  64'd0, 16'd0, 1'b1, QUIET},
        '{ACT_WRITE, OFS_RECV_REQ,  64'h0123_4567_89ab_cdef, 16'd0, 1'b0, QUIET},
        '{ACT_FRAME, OFS_SEND_REQ,  64'd0, 16'hffff, 1'b1,
          '{64'd0, ST_OK, 1'b0, 48'd0, 16'd0, 1'b1, 64'hffff_ffff_ffff_ffff, 16'hffff}},
        '{ACT_FRAME, OFS_SEND_REQ,  64'd0, 16'd0, 1'b1,
          '{64'd0, ST_OK, 1'b0, 48'd0, 16'd0, 1'b1, 64'd0, 16'd0}},
        '{ACT_READ,  OFS_COUNTS,    64'd0, 16'd0, 1'b0, QUIET},
        '{ACT_READ,  OFS_RECV_COMP, 64'd0, 16'd0, 1'b0, QUIET},
        '{ACT_READ,  OFS_SEND_COMP, 64'd0, 16'd0, 1'b0, QUIET},
        '{ACT_WRITE, OFS_MAC,       64'hffff_ffff_ffff_ffff, 16'd0, 1'b1,
          only_status(ST_BADOFS)},
        '{ACT_READ,  OFS_RECV_COMP, 64'd0, 16'd0, 1'b0, QUIET},
        '{ACT_READ,  OFS_RECV_COMP, 64'd0, 16'd0, 1'b0, QUIET},
        '{ACT_FRAME, OFS_TOP,       64'd0, 16'h8000, 1'b0, QUIET},
        '{ACT_WRITE, OFS_COUNTS,    64'd0, 16'd0, 1'b1, only_status(ST_BADOFS)}
    };

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [87:0]       s_axis_tdata  = '0;
    logic [ACT_W-1:0]  s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [RES_W-1:0]  m_axis_tdata;
    logic [STAT_W-1:0] m_axis_tuser;
    logic              cfg_wr_en     = 1'b0;
    logic [ADDR_W-1:0] cfg_wr_data   = '0;

    nic_descriptor_queue_registers #(
        .RX_SLOTS(RING_SLOTS),
        .TX_SLOTS(SEND_SLOTS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model state: receive ring, send completions, station address
    logic [WORD_W-1:0] ring_addr [RING_SLOTS];
    logic [LEN_W-1:0]  ring_len [RING_SLOTS];
    int                ring_head   = 0;
    int                ring_posted = 0;   // buffers held, filled or not
    int                ring_filled = 0;
    int                sends_done  = 0;
    logic [ADDR_W-1:0] station_mac = '0;

    reply_t replies_due [$];
    int     words_sent = 0;
    int     replies_seen = 0;
    int     mismatches = 0;
    int     status_seen [8];
    int     cycles = 0;
    int     snd_idle = 0;
    int     rcv_stall = 0;
    logic   hold_rx = 1'b0;

    function automatic reply_t mmio_step(input logic [ACT_W-1:0] act,
                                         input logic [OFS_W-1:0] ofs,
                                         input logic [WORD_W-1:0] wd,
                                         input logic [LEN_W-1:0] fl);
        reply_t r;
        int     slot;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_READ: begin
                if (ofs == OFS_SEND_COMP) begin
                    if (sends_done == 0) r.status = ST_EMPTY;
                    else sends_done--;
                end else if (ofs == OFS_RECV_COMP) begin
                    if (ring_filled == 0 || ring_posted == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.rdata = WORD_W'(ring_len[ring_head]);
                        ring_head = (ring_head + 1) % RING_SLOTS;
                        ring_filled--;
                        ring_posted--;
                    end
                end else if (ofs == OFS_COUNTS) begin
                    r.rdata[3:0]   = 4'(SEND_SLOTS);
                    r.rdata[7:4]   = 4'(RING_SLOTS - ring_posted);
                    r.rdata[11:8]  = 4'(sends_done);
                    r.rdata[15:12] = 4'(ring_filled);
                end else if (ofs == OFS_MAC) begin
                    r.rdata = WORD_W'(station_mac);
                end else begin
                    r.status = ST_BADOFS;
                end
            end
            ACT_WRITE: begin
                if (ofs == OFS_SEND_REQ) begin
                    // completion count saturates at 15
                    if (sends_done >= 15) begin
                        r.status = ST_FULL;
                    end else begin
                        r.tx_valid = 1'b1;
                        r.tx_addr  = wd[ADDR_W-1:0];
                        r.tx_len   = wd[WORD_W-1:ADDR_W];
                        sends_done++;
                    end
                end else if (ofs == OFS_RECV_REQ) begin
                    if (ring_posted >= RING_SLOTS) begin
                        r.status = ST_FULL;
                    end else begin
                        ring_addr[(ring_head + ring_posted) % RING_SLOTS] = wd;
                        ring_posted++;
                    end
                end else begin
                    r.status = ST_BADOFS;
                end
            end
            ACT_FRAME: begin
                // oldest posted buffer that is still empty takes the frame
                if (ring_filled < ring_posted) begin
                    slot = (ring_head + ring_filled) % RING_SLOTS;
                    ring_len[slot] = fl;
                    r.rx_valid = 1'b1;
                    r.rx_addr  = ring_addr[slot];
                    r.rx_len   = fl;
                    ring_filled++;
                end else begin
                    r.status = ST_DROP;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one word, predict its reply once it is taken, then maybe idle
    task automatic put_word(input logic [ACT_W-1:0] act, input logic [OFS_W-1:0] ofs,
                            input logic [WORD_W-1:0] wd, input logic [LEN_W-1:0] fl,
                            input logic fixed_exp = 1'b0, input reply_t fixed_want = '0);
        reply_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, fl, wd, ofs};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        r = mmio_step(act, ofs, wd, fl);
        if (fixed_exp) r = fixed_want;
        replies_due = {replies_due, r};
        if (act != ACT_NONE) words_sent++;
        if ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < snd_idle);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    // only called with nothing in flight
    task automatic set_mac(input logic [ADDR_W-1:0] mac);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mac;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        station_mac = mac;
    endtask

    // mostly descriptor sequences with random content, some noise
    task automatic run_traffic(input int n_words);
        int stop_at;
        int pick;
        int n;
        int k;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                n = $urandom_range(1, RING_SLOTS + 2);
                repeat (n) put_word(ACT_WRITE, OFS_RECV_REQ, rand64(), 16'($urandom));
                k = $urandom_range(0, n + 2);
                repeat (k) put_word(ACT_FRAME, 5'($urandom), rand64(), 16'($urandom));
                if ($urandom_range(1) == 1)
                    put_word(ACT_READ, OFS_COUNTS, rand64(), 16'($urandom));
                k = $urandom_range(0, k + 1);
                repeat (k) put_word(ACT_READ, OFS_RECV_COMP, rand64(), 16'($urandom));
            end else if (pick < 55) begin
                // long bursts push the send completion count into saturation
                n = $urandom_range(1, 18);
                repeat (n) put_word(ACT_WRITE, OFS_SEND_REQ, rand64(), 16'($urandom));
                k = $urandom_range(0, n + 1);
                repeat (k) put_word(ACT_READ, OFS_SEND_COMP, rand64(), 16'($urandom));
            end else if (pick < 70) begin
                case ($urandom_range(3))
                    0: put_word(ACT_READ, OFS_COUNTS, rand64(), 16'($urandom));
                    1: put_word(ACT_READ, OFS_MAC, rand64(), 16'($urandom));
                    2: put_word(ACT_READ, OFS_SEND_COMP, rand64(), 16'($urandom));
                    default: put_word(ACT_READ, OFS_RECV_COMP, rand64(), 16'($urandom));
                endcase
            end else begin
                put_word(2'($urandom), 5'($urandom), rand64(), 16'($urandom));
            end
        end
    endtask

    // result side: random stalls, plus the long hold-off
    always @(posedge aclk) begin
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= rcv_stall);
    end

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : reply_check
        reply_t got;
        reply_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.rdata    = m_axis_tdata[63:0];
            got.tx_valid = m_axis_tdata[64];
            got.tx_addr  = m_axis_tdata[112:65];
            got.tx_len   = m_axis_tdata[128:113];
            got.rx_valid = m_axis_tdata[129];
            got.rx_addr  = m_axis_tdata[193:130];
            got.rx_len   = m_axis_tdata[209:194];
            got.status   = m_axis_tuser;
            replies_seen++;
            status_seen[got.status]++;
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: reply word with none expected, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = replies_due.pop_front();
                check_field("rdata",          want.rdata,    got.rdata);
                check_field("status",         want.status,   got.status);
                check_field("tx_valid",       want.tx_valid, got.tx_valid);
                check_field("tx_addr",        want.tx_addr,  got.tx_addr);
                check_field("tx_len",         want.tx_len,   got.tx_len);
                check_field("rx_write_valid", want.rx_valid, got.rx_valid);
                check_field("rx_write_addr",  want.rx_addr,  got.rx_addr);
                check_field("rx_write_len",   want.rx_len,   got.rx_len);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, replies_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [ADDR_W-1:0] mac;
        foreach (ring_addr[i]) begin
            ring_addr[i] = '0;
            ring_len[i]  = '0;
        end
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling, MAC still at its reset value
        foreach (dir_rows[i])
            put_word(dir_rows[i].act, dir_rows[i].ofs, dir_rows[i].wdata,
                     dir_rows[i].flen, dir_rows[i].fixed_exp, dir_rows[i].want);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: mac = 48'hffff_ffff_ffff;
                1: mac = ADDR_W'(rand64());
                2: mac = 48'h0;
                default: mac = 48'h0000_0000_0001;
            endcase
            snd_idle = SND_IDLE[p];
            rcv_stall <= RCV_STALL[p];
            set_mac(mac);
            run_traffic(WORDS_PER_PHASE / 2);
            // sender holds off until every reply is back
            wait_drained();
            run_traffic(WORDS_PER_PHASE / 2);
            if (p == 2) begin
                // receiver blocked for a long stretch while words keep coming
                fork
                    begin
                        hold_rx <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_rx <= 1'b0;
                    end
                    run_traffic(40);
                join
            end
            wait_drained();
        end

        // idle on for any stray replies
        repeat (8) @(posedge aclk);
        $display("Run: %0d bus and frame words, %0d replies checked, four idling mixes,",
                 words_sent, replies_seen);
        $display("  long receiver hold-off; status ok %0d, bad offset %0d, empty %0d, %s %0d, %s %0d",
                 status_seen[ST_OK], status_seen[ST_BADOFS], status_seen[ST_EMPTY],
                 "full", status_seen[ST_FULL], "dropped", status_seen[ST_DROP]);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/nicdq_pkg.sv
rtl/nicdq_ctrl.sv
rtl/nicdq_dpath.sv
rtl/nic_descriptor_queue_registers.sv
bench/testbench.sv
